// File: rtl/csvrp_pkg.sv
// Shared types and constants of the CSV record parser.
package csvrp_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [7:0] SEP_RESET   = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  // Register indexes on the configuration port
  localparam logic [7:0] REG_SEPARATOR = 8'd0;
  localparam logic [7:0] REG_QUOTE     = 8'd1;

  // Result kinds
  localparam logic [2:0] KIND_BYTE      = 3'd0;
  localparam logic [2:0] KIND_FIELD     = 3'd1;
  localparam logic [2:0] KIND_FIELD_REC = 3'd2;
  localparam logic [2:0] KIND_DISCARD   = 3'd4;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [5:0] {
    MODE_REC_START   = 6'b000001,
    MODE_FIELD_START = 6'b000010,
    MODE_UNQUOTED    = 6'b000100,
    MODE_QUOTED      = 6'b001000,
    MODE_QUOTE_SEEN  = 6'b010000,
    MODE_SKIP_LF     = 6'b100000
  } mode_t;

  // One request: the results caused by one input byte (one or two).
  // A second result is always a content byte.
  typedef struct packed {
    logic [2:0] kind0;
    logic [7:0] byte0;
    logic       two;
    logic [7:0] byte1;
  } req_t;

endpackage

// File: rtl/csv_record_parser_top.sv
// Top level of the streaming CSV record parser.
// The first result of a byte passes through the request queue and then the output register.
// Throughput: one byte per cycle; a stray quote gives two results, so the output register
//   drains one result per cycle unless stalled and the 4-entry request queue absorbs it.
// Input stalls only while the request queue is full.
// Reset (rst_n low, synchronous): record start, empty queue, separator ',' quote '"'.
module csv_record_parser_top import csvrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] sep_r;
  logic [7:0] quote_r;
  logic       accept;
  logic       push;
  req_t       push_req;
  logic       full;
  logic       pop;
  logic       nonempty;
  req_t       head_req;

  // Configuration registers: always ready; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= SEP_RESET;
      quote_r <= QUOTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SEPARATOR) begin
        sep_r <= cfg_data;
      end
      if (cfg_index == REG_QUOTE) begin
        quote_r <= cfg_data;
      end
    end
  end

  // Hold the input while the queue has no room for a request.
  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Front: classify each byte and advance the quote state machine.
  csvrp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .sep_char        (sep_r),
    .quote_char      (quote_r),
    .push            (push),
    .push_req        (push_req)
  );

  // Queue: one request per byte that produces results.
  csvrp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head_req (head_req)
  );

  // Back: expand each request into its results and mark the last one.
  csvrp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nonempty  (nonempty),
    .head_req  (head_req),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: rtl/csvrp_fifo.sv
// Short request queue that decouples the parse front from the result back.
module csvrp_fifo import csvrp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output req_t head_req
);

  req_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign nonempty = (count_r != '0);
  assign head_req = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// File: rtl/csvrp_front.sv
// Parse front: accepts input bytes, runs the quote state machine, forms requests.
module csvrp_front import csvrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  input  logic [7:0] sep_char,
  input  logic [7:0] quote_char,
  output logic       push,
  output req_t       push_req
);

  mode_t mode_r, mode_nxt;
  logic  is_sep, is_lf, is_cr, is_quote;
  logic  emit;

  assign is_sep   = (in_byte == sep_char);
  assign is_lf    = (in_byte == CH_LF);
  assign is_cr    = (in_byte == CH_CR);
  assign is_quote = (in_byte == quote_char);

  always_comb begin
    mode_nxt       = mode_r;
    emit           = 1'b0;
    push_req.kind0 = KIND_BYTE;
    push_req.byte0 = '0;
    push_req.two   = 1'b0;
    push_req.byte1 = in_byte;
    if (in_end_of_input) begin
      mode_nxt = MODE_REC_START;
      case (mode_r)
        MODE_FIELD_START, MODE_UNQUOTED, MODE_QUOTE_SEEN: begin
          emit           = 1'b1;
          push_req.kind0 = KIND_FIELD_REC;
        end
        MODE_QUOTED: begin
          emit           = 1'b1;
          push_req.kind0 = KIND_DISCARD;
        end
        default: begin
        end
      endcase
    end else begin
      case (mode_r)
        MODE_UNQUOTED, MODE_QUOTE_SEEN: begin
          if (is_sep) begin
            emit           = 1'b1;
            push_req.kind0 = KIND_FIELD;
            mode_nxt       = MODE_FIELD_START;
          end else if (is_lf) begin
            emit           = 1'b1;
            push_req.kind0 = KIND_FIELD_REC;
            mode_nxt       = MODE_REC_START;
          end else if (is_cr) begin
            emit           = 1'b1;
            push_req.kind0 = KIND_FIELD_REC;
            mode_nxt       = MODE_SKIP_LF;
          end else if (mode_r == MODE_UNQUOTED) begin
            emit           = 1'b1;
            push_req.byte0 = in_byte;
          end else if (is_quote) begin
            // doubled quote: one quote byte
            emit           = 1'b1;
            push_req.byte0 = in_byte;
            mode_nxt       = MODE_QUOTED;
          end else begin
            // stray quote: keep it with the byte that follows
            emit           = 1'b1;
            push_req.byte0 = quote_char;
            push_req.two   = 1'b1;
            mode_nxt       = MODE_QUOTED;
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            mode_nxt = MODE_QUOTE_SEEN;
          end else begin
            emit           = 1'b1;
            push_req.byte0 = in_byte;
          end
        end
        MODE_SKIP_LF: begin
          if (is_lf) begin
            mode_nxt = MODE_REC_START;
          end
        end
        default: begin
          // start of a field
          if (is_sep) begin
            emit           = 1'b1;
            push_req.kind0 = KIND_FIELD;
            mode_nxt       = MODE_FIELD_START;
          end else if (is_lf) begin
            emit           = 1'b1;
            push_req.kind0 = KIND_FIELD_REC;
            mode_nxt       = MODE_REC_START;
          end else if (is_cr) begin
            emit           = 1'b1;
            push_req.kind0 = KIND_FIELD_REC;
            mode_nxt       = MODE_SKIP_LF;
          end else if (is_quote) begin
            mode_nxt = MODE_QUOTED;
          end else begin
            emit           = 1'b1;
            push_req.byte0 = in_byte;
            mode_nxt       = MODE_UNQUOTED;
          end
        end
      endcase
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_REC_START;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// File: rtl/csvrp_back.sv
// Result back: drains queued requests into the output register, one result a cycle while not stalled.
module csvrp_back import csvrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       nonempty,
  input  req_t       head_req,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       valid_r, valid_nxt;
  logic       second_r, second_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt  = valid_r;
    second_nxt = second_r;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    pop        = 1'b0;
    if (load) begin
      valid_nxt = nonempty;
      if (nonempty) begin
        if (!second_r) begin
          kind_nxt = head_req.kind0;
          byte_nxt = head_req.byte0;
          last_nxt = !head_req.two;
          if (head_req.two) begin
            second_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          kind_nxt   = KIND_BYTE;
          byte_nxt   = head_req.byte1;
          last_nxt   = 1'b1;
          second_nxt = 1'b0;
          pop        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

// File: rtl/csvrp_checker.sv
// Port-level checker for the CSV record parser, bound to the top level.
module csvrp_checker import csvrp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Only defined kinds leave the block.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_BYTE || out_kind == KIND_FIELD ||
                   out_kind == KIND_FIELD_REC || out_kind == KIND_DISCARD))
    else $error("illegal result kind");

  // Marks carry a zero byte.
  a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_BYTE) |-> (out_byte == 8'd0))
    else $error("mark with nonzero byte");

  // Only a content byte can be followed by another result of the same request.
  a_not_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_kind == KIND_BYTE))
    else $error("non-final result is not a byte");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind csv_record_parser_top csvrp_checker u_csvrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

// File: sim/tb.sv
// Self-checking testbench for the streaming CSV record parser.
`timescale 1ns / 100ps

import csvrp_pkg::*;

typedef struct packed {
  logic [2:0] kind;
  logic [7:0] data;
  logic       last;
} csv_mark_t;

class csv_mark_board;
  logic [7:0] sep;
  logic [7:0] quote;
  mode_t      mode;
  csv_mark_t  marks_due[$];
  int         errors;
  int         marks_checked;

  function new();
    sep           = SEP_RESET;
    quote         = QUOTE_RESET;
    mode          = MODE_REC_START;
    errors        = 0;
    marks_checked = 0;
  endfunction

  function void set_reg(logic [7:0] idx, logic [7:0] val);
    if (idx == REG_SEPARATOR) sep = val;
    else if (idx == REG_QUOTE) quote = val;
  endfunction

  function int pending();
    return marks_due.size();
  endfunction

  function void add_mark(logic [2:0] kind, logic [7:0] data);
    csv_mark_t m;
    m.kind = kind;
    m.data = data;
    m.last = 1'b0;
    marks_due.push_back(m);
  endfunction

  // Separator, then LF, then CR close the field; returns 0 if c does none of that.
  function bit close_field(logic [7:0] c);
    if (c == sep) begin
      add_mark(KIND_FIELD, 8'h00);
      mode = MODE_FIELD_START;
      return 1'b1;
    end else if (c == CH_LF) begin
      add_mark(KIND_FIELD_REC, 8'h00);
      mode = MODE_REC_START;
      return 1'b1;
    end else if (c == CH_CR) begin
      add_mark(KIND_FIELD_REC, 8'h00);
      mode = MODE_SKIP_LF;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Predict the marks of one accepted request; returns 0 if the byte is ignored.
  function bit parse_byte(logic [7:0] c, logic eoi);
    int        prior;
    mode_t     was;
    csv_mark_t m;
    prior = marks_due.size();
    was   = mode;
    if (eoi) begin
      case (mode)
        MODE_FIELD_START, MODE_UNQUOTED, MODE_QUOTE_SEEN: add_mark(KIND_FIELD_REC, 8'h00);
        MODE_QUOTED: add_mark(KIND_DISCARD, 8'h00);
        default: ;
      endcase
      mode = MODE_REC_START;
    end else begin
      case (mode)
        MODE_UNQUOTED: begin
          if (!close_field(c)) add_mark(KIND_BYTE, c);
        end
        MODE_QUOTED: begin
          if (c == quote) mode = MODE_QUOTE_SEEN;
          else add_mark(KIND_BYTE, c);
        end
        MODE_QUOTE_SEEN: begin
          if (!close_field(c)) begin
            if (c != quote) add_mark(KIND_BYTE, quote);
            add_mark(KIND_BYTE, c);
            mode = MODE_QUOTED;
          end
        end
        MODE_SKIP_LF: begin
          if (c == CH_LF) mode = MODE_REC_START;
        end
        default: begin
          if (!close_field(c)) begin
            if (c == quote) begin
              mode = MODE_QUOTED;
            end else begin
              add_mark(KIND_BYTE, c);
              mode = MODE_UNQUOTED;
            end
          end
        end
      endcase
    end
    if (marks_due.size() > prior) begin
      m = marks_due.pop_back();
      m.last = 1'b1;
      marks_due.push_back(m);
    end
    return (marks_due.size() > prior) || (mode != was);
  endfunction

  task report(string what);
    errors++;
    if (errors <= 30) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_mark(logic [2:0] kind, logic [7:0] data, logic last);
    csv_mark_t want;
    if (marks_due.size() == 0) begin
      report($sformatf("unexpected result kind %0d byte %02h last %0d", kind, data, last));
    end else begin
      want = marks_due.pop_front();
      marks_checked++;
      if (kind !== want.kind)
        report($sformatf("kind %0d, want %0d", kind, want.kind));
      if (data !== want.data)
        report($sformatf("byte %02h, want %02h", data, want.data));
      if (last !== want.last)
        report($sformatf("last %0d, want %0d", last, want.last));
    end
  endtask
endclass

module tb;

  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 136;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [8:0] EOI_MARK = 9'h100;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte         = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall       = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_valid       = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index       = 8'h00;
  logic [7:0] cfg_data        = 8'h00;

  csv_mark_board sb = new();

  int cycle_count  = 0;
  int work_items   = 0;
  int burst_left   = 0;
  int stall_cycles = 0;
  bit hold_req     = 1'b0;
  int hold_left    = 0;
  int pat          = 0;
  int pat_left     = 0;

  csv_record_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // Abort on a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver: switch between stall patterns of random length. A hold request
  // from the stimulus freezes the output for a long stretch so the internal
  // request queue fills and the input side has to stall.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (pat_left == 0) begin
        pat      = $urandom_range(0, 3);
        pat_left = $urandom_range(20, 200);
      end
      pat_left--;
      case (pat)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Check every result taken by the receiver against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_mark(out_kind, out_byte, out_last);
  end

  // Offer one request; open a new burst after a random gap when the last one ran out.
  // Hold valid high across back-to-back requests.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid        <= 1'b0;
        in_byte         <= 8'($urandom_range(0, 255));
        in_end_of_input <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) begin
      stall_cycles++;
      @(posedge clk);
    end
    if (sb.parse_byte(b, eoi)) work_items++;
  endtask

  // Drop valid, wait for every predicted result, then let in-flight silent bytes retire.
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between the two writes.
  task automatic write_regs(input logic [7:0] sep_val, input logic [7:0] quote_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SEPARATOR;
    cfg_data  <= sep_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_QUOTE;
    cfg_data  <= quote_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(REG_SEPARATOR, sep_val);
    sb.set_reg(REG_QUOTE, quote_val);
  endtask

  // Any byte that neither separates, quotes nor ends a line under the current setting.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == sb.sep || b == sb.quote || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // Well-formed record with random content: mixed quoted and unquoted fields,
  // doubled and stray quotes, and the usual line endings (plus a few broken ones).
  task automatic gen_record();
    int         nf;
    int         len;
    int         r;
    logic [7:0] b;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_item(sb.sep, 1'b0);
      len = $urandom_range(0, 6);
      if ($urandom_range(0, 9) < 4) begin
        send_item(sb.quote, 1'b0);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 9);
          if (r == 0) begin
            send_item(sb.quote, 1'b0);
            send_item(sb.quote, 1'b0);
          end else if (r == 1) begin
            send_item(sb.quote, 1'b0);
            send_item(plain_byte(), 1'b0);
          end else begin
            b = 8'($urandom_range(0, 255));
            if (b == sb.quote) b = ~b;
            send_item(b, 1'b0);
          end
        end
        send_item(sb.quote, 1'b0);
      end else begin
        for (int i = 0; i < len; i++) send_item(plain_byte(), 1'b0);
      end
    end
    r = $urandom_range(0, 9);
    if (r <= 4) begin
      send_item(CH_LF, 1'b0);
    end else if (r <= 6) begin
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
    end else if (r == 7) begin
      send_item(CH_CR, 1'b0);
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        send_item((b == CH_LF) ? (b ^ 8'h01) : b, 1'b0);
      end
      send_item(CH_LF, 1'b0);
    end else if (r == 8) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_item(CH_CR, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Short burst of noise, heavy on the special bytes and end-of-input.
  task automatic gen_noise();
    int n;
    int r;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 11);
      if (r == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 6) begin
        case ($urandom_range(0, 3))
          0: send_item(sb.sep, 1'b0);
          1: send_item(sb.quote, 1'b0);
          2: send_item(CH_CR, 1'b0);
          default: send_item(CH_LF, 1'b0);
        endcase
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  initial begin
    logic [8:0] directed_seq [$];
    logic [7:0] phase_sep [$];
    logic [7:0] phase_quote [$];
    int         start;

    // Directed opening under the reset setting: empty lines with LF and CR,
    // skipping up to LF, byte extremes, separators and newlines inside quotes,
    // doubled quote, stray quote, trailing separator at end of input,
    // end of input at record start, while skipping, inside an open quote
    // and right after a closing quote.
    directed_seq = '{
      {1'b0, CH_LF}, {1'b0, CH_CR}, 9'h078, {1'b0, CH_LF},
      9'h0FF, {1'b0, SEP_RESET}, 9'h000, {1'b0, CH_CR}, EOI_MARK,
      {1'b0, QUOTE_RESET}, {1'b0, SEP_RESET}, {1'b0, QUOTE_RESET},
      {1'b0, QUOTE_RESET}, {1'b0, QUOTE_RESET}, 9'h07A, {1'b0, QUOTE_RESET},
      {1'b0, SEP_RESET}, EOI_MARK, EOI_MARK,
      {1'b0, QUOTE_RESET}, {1'b0, CH_LF}, EOI_MARK,
      {1'b0, QUOTE_RESET}, {1'b0, QUOTE_RESET}, EOI_MARK
    };

    // Settings per phase: reset, common alternatives, both byte extremes,
    // separator equal to quote, quote on LF, a random pair, then back to reset.
    phase_sep   = '{SEP_RESET, 8'h3B, 8'h00, 8'hFF, 8'h09, 8'h7C, SEP_RESET, 8'h00,
                    SEP_RESET};
    phase_quote = '{QUOTE_RESET, 8'h27, 8'hFF, 8'h00, QUOTE_RESET, 8'h7C, CH_LF,
                    8'h00, QUOTE_RESET};
    phase_sep[7]   = 8'($urandom_range(0, 255));
    phase_quote[7] = 8'($urandom_range(0, 255));

    // Hold reset low at the start, then release it once.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_seq[i]) send_item(directed_seq[i][7:0], directed_seq[i][8]);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        write_regs(phase_sep[p], phase_quote[p]);
      end
      // Freeze the receiver once while requests keep coming.
      if (p == 2) hold_req = 1'b1;
      start = work_items;
      while (work_items - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) gen_record();
        else gen_noise();
      end
    end

    // Drain everything still predicted, then give late extras a chance to show up.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected results left over");

    $display("run: %0d parsed bytes, %0d results checked, %0d separator/quote settings",
             work_items, sb.marks_checked, PHASES);
    $display("run: input held off for %0d cycles, %0d cycles in total",
             stall_cycles, cycle_count);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
